@@ hw/rtl/bcd_pkg.sv @@
// shared types, codes and helpers for the button chord and hold decoder
package bcd_pkg;

  localparam int unsigned CntW   = 16;
  localparam int unsigned ThrW   = 8;
  localparam int unsigned BtnW   = 3;
  localparam int unsigned PulseW = 8;
  localparam int unsigned EvW    = 3;
  localparam int unsigned InDataW  = 16;
  localparam int unsigned OutDataW = 16;
  localparam int unsigned CfgAddrW = 2;

  localparam logic [CntW-1:0] CntMax = {CntW{1'b1}};

  typedef enum logic [EvW-1:0] {
    EV_NONE      = 3'd0,
    EV_SET       = 3'd1,
    EV_STARTSTOP = 3'd2,
    EV_MODE      = 3'd3,
    EV_TIRE      = 3'd4,
    EV_RESET     = 3'd5,
    EV_TRIP      = 3'd6
  } bcd_event_t;

  typedef enum logic [CfgAddrW-1:0] {
    REG_SHORT_HOLD = 2'd0,
    REG_LONG_HOLD  = 2'd1,
    REG_REPEAT     = 2'd2
  } bcd_reg_t;

  typedef struct packed {
    logic [ThrW-1:0] short_hold_ticks;
    logic [ThrW-1:0] long_hold_ticks;
    logic [ThrW-1:0] repeat_ticks;
  } bcd_cfg_t;

  typedef struct packed {
    logic [BtnW-1:0]   previous_buttons;
    logic [PulseW-1:0] last_pulses;
    logic [CntW-1:0]   hold_count;
    logic [CntW-1:0]   repeat_count;
    logic              chord_reset_pending;
    logic              chord_trip_pending;
    logic              mode_fired;
  } bcd_state_t;

  typedef struct packed {
    logic              wheel_event;
    logic [PulseW-1:0] rotations;
    bcd_event_t        button_event;
  } bcd_result_t;

  // saturating increment of a hold or repeat counter
  function automatic logic [CntW-1:0] sat_inc(input logic [CntW-1:0] v);
    return (v == CntMax) ? CntMax : v + 1'b1;
  endfunction

endpackage

@@ hw/rtl/bcd_cfg.sv @@
// threshold registers written through the plain configuration port
module bcd_cfg
  import bcd_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [CfgAddrW-1:0] cfg_addr,
  input  logic [ThrW-1:0]     cfg_data,
  output bcd_cfg_t            cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.short_hold_ticks <= ThrW'(1);
      cfg.long_hold_ticks  <= ThrW'(10);
      cfg.repeat_ticks     <= ThrW'(5);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_SHORT_HOLD: cfg.short_hold_ticks <= cfg_data;
        REG_LONG_HOLD:  cfg.long_hold_ticks  <= cfg_data;
        REG_REPEAT:     cfg.repeat_ticks     <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

@@ hw/rtl/bcd_decode.sv @@
// per-tick decode: next state and result from current state and one tick
module bcd_decode
  import bcd_pkg::*;
(
  input  bcd_cfg_t           cfg,
  input  bcd_state_t         st,
  input  logic [BtnW-1:0]    buttons,
  input  logic [PulseW-1:0]  pulse_count,
  output bcd_state_t         st_next,
  output bcd_result_t        res
);

  logic [CntW-1:0] short_thr;
  logic [CntW-1:0] long_thr;
  logic [CntW-1:0] rep_thr;
  logic [CntW-1:0] hc_chord;
  logic [CntW-1:0] rc_inc;
  logic            b1, b2, b3, p1, p2, p3, prev_sel;
  bcd_event_t      ev;

  assign short_thr = CntW'(cfg.short_hold_ticks);
  assign long_thr  = CntW'(cfg.long_hold_ticks);
  assign rep_thr   = CntW'(cfg.repeat_ticks);

  assign b1 = buttons[0];
  assign b2 = buttons[1];
  assign b3 = buttons[2];
  assign p1 = st.previous_buttons[0];
  assign p2 = st.previous_buttons[1];
  assign p3 = st.previous_buttons[2];
  assign prev_sel = b1 ? p1 : p2;
  assign rc_inc   = sat_inc(st.repeat_count);

  always_comb begin
    st_next = st;
    ev      = EV_NONE;
    st_next.previous_buttons = buttons;
    st_next.last_pulses      = pulse_count;
    hc_chord = '0;

    if (b1 && b2 && b3) begin
      // three-button reset chord
      hc_chord = st.chord_reset_pending ? sat_inc(st.hold_count) : CntW'(1);
      st_next.chord_reset_pending = 1'b1;
      if (hc_chord >= long_thr) begin
        ev = EV_RESET;
        st_next.hold_count = '0;
      end else begin
        st_next.hold_count = hc_chord;
      end
    end else if (b2 && b3) begin
      // start-stop plus mode trip reset chord
      hc_chord = st.chord_trip_pending ? sat_inc(st.hold_count) : CntW'(1);
      st_next.chord_trip_pending = 1'b1;
      if (hc_chord >= long_thr) begin
        ev = EV_TRIP;
        st_next.hold_count = '0;
      end else begin
        st_next.hold_count = hc_chord;
      end
    end else if (b1 || b2) begin
      if (!prev_sel) begin
        st_next.hold_count = CntW'(1);
      end else begin
        if (st.hold_count >= short_thr) ev = b1 ? EV_SET : EV_STARTSTOP;
        st_next.hold_count = sat_inc(st.hold_count);
      end
    end else if (b3) begin
      if (!p3) begin
        st_next.hold_count = CntW'(1);
      end else begin
        if (st.hold_count >= long_thr) begin
          // long mode hold: step tire size every repeat interval
          if (rc_inc >= rep_thr) begin
            ev = EV_TIRE;
            st_next.repeat_count = '0;
          end else begin
            st_next.repeat_count = rc_inc;
          end
        end else if (st.hold_count >= short_thr && !st.mode_fired) begin
          ev = EV_MODE;
          st_next.mode_fired = 1'b1;
        end
        st_next.hold_count = sat_inc(st.hold_count);
      end
    end else begin
      // all released: quick press if short enough
      if (st.hold_count <= short_thr) begin
        if (p1)      ev = EV_SET;
        else if (p2) ev = EV_STARTSTOP;
        else if (p3) ev = EV_MODE;
      end
      st_next.chord_reset_pending = 1'b0;
      st_next.chord_trip_pending  = 1'b0;
      st_next.hold_count          = '0;
      st_next.repeat_count        = '0;
      st_next.mode_fired          = 1'b0;
    end
  end

  assign res.wheel_event  = (pulse_count != st.last_pulses);
  assign res.rotations    = pulse_count;
  assign res.button_event = ev;

endmodule

@@ hw/rtl/button_chord_hold_decoder.sv @@
// top level: input register, per-tick decode with state, result register
// a tick passes through the input register, then the result register
// throughput: one tick per cycle while the master side is ready; the state update is a
//   single short pass through the decode logic, so back-to-back ticks need no extra stall
// reset (rst, synchronous): clears both stages, all decode state and loads
//   thresholds short 1, long 10, repeat 5
module button_chord_hold_decoder
  import bcd_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  // slave side: tick input
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [InDataW-1:0]  s_tdata,   // [2:0] buttons, [10:3] pulse_count, rest zero
  // master side: one result per tick
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [OutDataW-1:0] m_tdata,   // [0] wheel_event, [8:1] rotations,
                                         // [11:9] button_event, rest zero
  // configuration write port
  input  logic                cfg_we,
  input  logic [CfgAddrW-1:0] cfg_addr,
  input  logic [ThrW-1:0]     cfg_data
);

  bcd_cfg_t          cfg;
  bcd_state_t        st;
  bcd_state_t        st_next;
  bcd_result_t       res;
  bcd_result_t       out_res;
  logic              in_valid;
  logic [BtnW-1:0]   in_buttons;
  logic [PulseW-1:0] in_pulses;
  logic              out_free;
  logic              adv;

  bcd_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .cfg      (cfg)
  );

  bcd_decode u_decode (
    .cfg         (cfg),
    .st          (st),
    .buttons     (in_buttons),
    .pulse_count (in_pulses),
    .st_next     (st_next),
    .res         (res)
  );

  // result register is free when empty or being taken this cycle
  assign out_free = !m_tvalid || m_tready;
  // a registered tick is decoded and its state committed as it moves on
  assign adv      = in_valid && out_free;
  assign s_tready = !in_valid || out_free;

  // control and decode state
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      m_tvalid <= 1'b0;
      st       <= '0;
    end else begin
      if (s_tready) in_valid <= s_tvalid;
      if (adv) begin
        m_tvalid <= 1'b1;
        st       <= st_next;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_buttons <= s_tdata[BtnW-1:0];
      in_pulses  <= s_tdata[BtnW+PulseW-1:BtnW];
    end
    if (adv) out_res <= res;
  end

  assign m_tdata = {4'b0000, out_res.button_event, out_res.rotations, out_res.wheel_event};

  // a decoded transaction always lands in the result register
  a_adv_fills_out: assert property (@(posedge clk) disable iff (rst)
    adv |=> m_tvalid)
    else $error("decoded transaction did not reach result register");

  // releasing every button always clears the hold counter and the mode flag
  a_release_clears: assert property (@(posedge clk) disable iff (rst)
    (adv && in_buttons == '0) |=> (st.hold_count == '0 && !st.mode_fired))
    else $error("hold counter not cleared on release");

  // unused event code never appears
  a_event_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[11:9] != 3'd7))
    else $error("invalid button event code");

  // mode press flag only rises while mode alone is held
  a_mode_flag: assert property (@(posedge clk) disable iff (rst)
    $rose(st.mode_fired) |-> $past(in_buttons == 3'b100))
    else $error("mode flag set without mode held");

endmodule

@@ tb/tb_button_chord_hold_decoder.sv @@
// testbench for the button chord and hold decoder: directed script, shaped random gestures
`timescale 1ns / 1ps

module tb_button_chord_hold_decoder;
  import bcd_pkg::*;

  // cycles with no transaction on either side before the run is abandoned
  localparam int QuietLimit = 2000;
  // script row at which the short directed thresholds are loaded for the chord checks
  localparam int ChordRow = 11;
  // input budget of each random phase, six phases in all
  localparam int PhaseTicks = 330;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [InDataW-1:0]  s_tdata = '0;   // [2:0] buttons, [10:3] pulse_count
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [OutDataW-1:0] m_tdata;        // [0] wheel_event, [8:1] rotations, [11:9] button_event
  logic                cfg_we = 1'b0;
  logic [CfgAddrW-1:0] cfg_addr = '0;
  logic [ThrW-1:0]     cfg_data = '0;

  button_chord_hold_decoder dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data)
  );

  always #6 clk = ~clk;

  // ---------------------------------------------------------------------------
  // predictor: private copy of the decode state and the thresholds
  // ---------------------------------------------------------------------------
  logic [BtnW-1:0]   prev_btn;
  logic [PulseW-1:0] last_rot;
  logic [CntW-1:0]   hold_cnt;
  logic [CntW-1:0]   rep_cnt;
  logic              reset_armed;   // three-button chord already counting
  logic              trip_armed;    // start-stop plus mode chord already counting
  logic              mode_done;     // mode press already reported in this hold
  logic [ThrW-1:0]   thr_short;
  logic [ThrW-1:0]   thr_long;
  logic [ThrW-1:0]   thr_rep;

  bcd_result_t predicted_reports[$];   // one decoded report per accepted tick, oldest first
  int          bad_fields = 0;
  int          ticks_sent = 0;
  int          quiet_cycles = 0;
  logic        steady = 1'b0;          // both sides run flat out while set
  logic [PulseW-1:0] wheel_now = '0;

  // counters stick at all ones rather than wrapping
  function automatic logic [CntW-1:0] bump(input logic [CntW-1:0] v);
    return (v == {CntW{1'b1}}) ? v : v + 1'b1;
  endfunction

  function automatic bcd_result_t decode_tick(input logic [BtnW-1:0] btn,
                                              input logic [PulseW-1:0] pulses);
    bcd_result_t r;
    r.wheel_event  = (pulses != last_rot);
    r.rotations    = pulses;
    r.button_event = EV_NONE;
    last_rot = pulses;
    if (btn == 3'b111) begin
      // three-button reset; the count only restarts on a fresh chord
      if (!reset_armed) hold_cnt = '0;
      hold_cnt = bump(hold_cnt);
      reset_armed = 1'b1;
      if (hold_cnt >= thr_long) begin
        r.button_event = EV_RESET;
        hold_cnt = '0;
      end
    end else if (btn[1] && btn[2]) begin
      // start-stop plus mode trip reset
      if (!trip_armed) hold_cnt = '0;
      hold_cnt = bump(hold_cnt);
      trip_armed = 1'b1;
      if (hold_cnt >= thr_long) begin
        r.button_event = EV_TRIP;
        hold_cnt = '0;
      end
    end else if (btn[0] || btn[1]) begin
      // held set or start-stop repeats every tick once past the short hold
      if (!(btn[0] ? prev_btn[0] : prev_btn[1])) hold_cnt = '0;
      else if (hold_cnt >= thr_short) r.button_event = btn[0] ? EV_SET : EV_STARTSTOP;
      hold_cnt = bump(hold_cnt);
    end else if (btn[2]) begin
      // mode alone: one mode event, then tire steps once held long
      if (!prev_btn[2]) begin
        hold_cnt = '0;
      end else if (hold_cnt >= thr_long) begin
        rep_cnt = bump(rep_cnt);
        if (rep_cnt >= thr_rep) begin
          r.button_event = EV_TIRE;
          rep_cnt = '0;
        end
      end else if (hold_cnt >= thr_short && !mode_done) begin
        r.button_event = EV_MODE;
        mode_done = 1'b1;
      end
      hold_cnt = bump(hold_cnt);
    end else begin
      // all released: a quick release reports the button that was down
      if (hold_cnt <= thr_short) begin
        if (prev_btn[0])      r.button_event = EV_SET;
        else if (prev_btn[1]) r.button_event = EV_STARTSTOP;
        else if (prev_btn[2]) r.button_event = EV_MODE;
      end
      reset_armed = 1'b0;
      trip_armed  = 1'b0;
      hold_cnt    = '0;
      rep_cnt     = '0;
      mode_done   = 1'b0;
    end
    prev_btn = btn;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // tick driver; called at a rising edge, returns at the edge of the transaction
  // ready is looked at on the falling edge, where everything has settled
  // ---------------------------------------------------------------------------
  task automatic send_tick(input logic [BtnW-1:0] btn, input logic [PulseW-1:0] pulses,
                           input logic typed, input bcd_result_t want);
    bcd_result_t guess;
    while (!steady && $urandom_range(99) < 32) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(InDataW-BtnW-PulseW){1'b0}}, pulses, btn};
    forever begin
      @(negedge clk);
      if (s_tready) break;
      @(posedge clk);
    end
    // predictor always runs so its state follows the block; typed rows override it
    guess = decode_tick(btn, pulses);
    predicted_reports.push_back(typed ? want : guess);
    ticks_sent++;
    @(posedge clk);
  endtask

  // stop sending and let every outstanding report drain
  task automatic drain();
    s_tvalid <= 1'b0;
    while (predicted_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // thresholds are only written with the block idle
  task automatic load_thresholds(input logic [ThrW-1:0] sh, input logic [ThrW-1:0] lo,
                                 input logic [ThrW-1:0] rp);
    cfg_we   <= 1'b1;
    cfg_addr <= REG_SHORT_HOLD;
    cfg_data <= sh;
    @(posedge clk);
    cfg_addr <= REG_LONG_HOLD;
    cfg_data <= lo;
    @(posedge clk);
    cfg_addr <= REG_REPEAT;
    cfg_data <= rp;
    @(posedge clk);
    cfg_we    <= 1'b0;
    thr_short = sh;
    thr_long  = lo;
    thr_rep   = rp;
  endtask

  // wheel count mostly repeats, so quiet ticks and wheel events both occur
  function automatic logic [PulseW-1:0] next_pulses();
    if ($urandom_range(99) < 30) wheel_now = PulseW'($urandom_range(255));
    return wheel_now;
  endfunction

  // one press gesture: a combination held for some span, with the odd glitch,
  // sometimes chained into the other chord, usually followed by a release
  task automatic play_gesture();
    int pick;
    int span;
    int n;
    logic [BtnW-1:0] combo;
    pick = $urandom_range(99);
    if (pick < 12) begin
      // noise: unrelated button levels every tick
      span = $urandom_range(1, 8);
      for (n = 0; n < span; n++)
        send_tick(BtnW'($urandom_range(7)), PulseW'($urandom_range(255)), 1'b0, '0);
    end else begin
      case ($urandom_range(6))
        0:       combo = 3'b001;
        1:       combo = 3'b010;
        2:       combo = 3'b100;
        3:       combo = 3'b011;
        4:       combo = 3'b101;
        5:       combo = 3'b110;
        default: combo = 3'b111;
      endcase
      pick = $urandom_range(99);
      if (pick < 30)      span = $urandom_range(1, int'(thr_short) + 1);
      else if (pick < 60) span = $urandom_range(1, int'(thr_long) + 2);
      else span = int'(thr_long) + int'(thr_rep) * $urandom_range(0, 3) + $urandom_range(0, 2);
      for (n = 0; n < span; n++) begin
        if ($urandom_range(99) < 4) send_tick(BtnW'($urandom_range(7)), next_pulses(), 1'b0, '0);
        else send_tick(combo, next_pulses(), 1'b0, '0);
      end
      // slide from one chord to the other without letting go
      if (combo[2] && combo[1] && $urandom_range(99) < 25) begin
        span = $urandom_range(1, int'(thr_long) + 2);
        for (n = 0; n < span; n++) send_tick(combo ^ 3'b001, next_pulses(), 1'b0, '0);
      end
    end
    if ($urandom_range(99) < 85) begin
      span = $urandom_range(1, 3);
      for (n = 0; n < span; n++) send_tick(3'b000, next_pulses(), 1'b0, '0);
    end
  endtask

  // ---------------------------------------------------------------------------
  // result side: random back-pressure, checked on the falling edge
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    m_tready <= steady || ($urandom_range(99) >= 32);
  end

  always @(negedge clk) begin
    bcd_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (predicted_reports.size() == 0) begin
        $error("result transaction with no tick outstanding: %h", m_tdata);
        bad_fields++;
      end else begin
        want = predicted_reports.pop_front();
        if (m_tdata[0] !== want.wheel_event) begin
          $error("wheel_event: expected %0d, got %0d", want.wheel_event, m_tdata[0]);
          bad_fields++;
        end
        if (m_tdata[8:1] !== want.rotations) begin
          $error("rotations: expected %0d, got %0d", want.rotations, m_tdata[8:1]);
          bad_fields++;
        end
        if (m_tdata[11:9] !== want.button_event) begin
          $error("button_event: expected %0d, got %0d", want.button_event, m_tdata[11:9]);
          bad_fields++;
        end
      end
    end
  end

  // watchdog: a long spell with no transaction on either side ends the run
  always @(negedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QuietLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  typedef struct packed {
    logic              typed;    // want holds a hand-worked report
    logic [BtnW-1:0]   btn;
    logic [PulseW-1:0] pulses;
    bcd_result_t       want;
  } script_row_t;

  script_row_t script[$];

  initial begin
    int i;
    int p;

    // predictor starts from the reset state
    prev_btn = '0; last_rot = '0; hold_cnt = '0; rep_cnt = '0;
    reset_armed = 1'b0; trip_armed = 1'b0; mode_done = 1'b0;
    thr_short = 8'd1; thr_long = 8'd10; thr_rep = 8'd5;

    // reset thresholds: quick releases of each button, full-scale wheel counts
    script.push_back({1'b1, 3'b000, 8'd0,   1'b0, 8'd0,   EV_NONE});
    script.push_back({1'b1, 3'b000, 8'd255, 1'b1, 8'd255, EV_NONE});
    script.push_back({1'b1, 3'b001, 8'd255, 1'b0, 8'd255, EV_NONE});
    script.push_back({1'b1, 3'b000, 8'd0,   1'b1, 8'd0,   EV_SET});
    script.push_back({1'b1, 3'b010, 8'd0,   1'b0, 8'd0,   EV_NONE});
    script.push_back({1'b1, 3'b000, 8'd0,   1'b0, 8'd0,   EV_STARTSTOP});
    script.push_back({1'b1, 3'b100, 8'd1,   1'b1, 8'd1,   EV_NONE});
    script.push_back({1'b1, 3'b000, 8'd1,   1'b0, 8'd1,   EV_MODE});
    // held set auto-repeats, then a slow release reports nothing
    script.push_back({1'b0, 3'b001, 8'd2, 12'd0});
    script.push_back({1'b0, 3'b001, 8'd2, 12'd0});
    script.push_back({1'b0, 3'b000, 8'd3, 12'd0});
    // short thresholds from here: reset chord, held on without restarting
    script.push_back({1'b0, 3'b111, 8'd3, 12'd0});
    script.push_back({1'b0, 3'b111, 8'd3, 12'd0});
    script.push_back({1'b0, 3'b111, 8'd4, 12'd0});
    script.push_back({1'b0, 3'b111, 8'd4, 12'd0});
    // drop into the trip chord, which starts its own count
    script.push_back({1'b0, 3'b110, 8'd4, 12'd0});
    script.push_back({1'b0, 3'b110, 8'd5, 12'd0});
    script.push_back({1'b0, 3'b110, 8'd5, 12'd0});
    script.push_back({1'b0, 3'b000, 8'd5, 12'd0});
    // mode held through the mode event into tire steps
    script.push_back({1'b0, 3'b100, 8'd6, 12'd0});
    script.push_back({1'b0, 3'b100, 8'd6, 12'd0});
    script.push_back({1'b0, 3'b100, 8'd6, 12'd0});
    script.push_back({1'b0, 3'b100, 8'd7, 12'd0});
    script.push_back({1'b0, 3'b100, 8'd7, 12'd0});
    // two-button press that is not a chord: set wins
    script.push_back({1'b0, 3'b101, 8'd7, 12'd0});
    script.push_back({1'b0, 3'b000, 8'd7, 12'd0});

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    for (i = 0; i < script.size(); i++) begin
      if (i == ChordRow) begin
        drain();
        load_thresholds(8'd2, 8'd3, 8'd2);
      end
      send_tick(script[i].btn, script[i].pulses, script[i].typed, script[i].want);
    end

    // random phases over a spread of thresholds, extremes among them
    for (p = 0; p < 6; p++) begin
      drain();
      case (p)
        0:       load_thresholds(8'd2, 8'd4, 8'd3);
        1:       load_thresholds(8'd1, 8'd1, 8'd1);
        2:       load_thresholds(8'd255, 8'd255, 8'd255);
        3:       load_thresholds(8'd5, 8'd20, 8'd4);
        default: load_thresholds(ThrW'($urandom_range(1, 12)), ThrW'($urandom_range(1, 40)),
                                 ThrW'($urandom_range(1, 10)));
      endcase
      // one phase with no idling on either side
      steady = (p == 1);
      i = ticks_sent + PhaseTicks;
      while (ticks_sent < i) play_gesture();
    end
    steady = 1'b0;

    drain();
    repeat (4) @(posedge clk);
    if (bad_fields == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
